// ===== rtl/fm2op_pkg.sv =====
// Package for the two-operator FM voice: ROM tables, register codes and the operator function.
package fm2op_pkg;

	typedef enum logic [2:0] {
		REG_TOTAL_LEVEL   = 3'd0,
		REG_FEEDBACK      = 3'd1,
		REG_VOLUME        = 3'd2,
		REG_MOD_KEY_SCALE = 3'd3,
		REG_CAR_KEY_SCALE = 3'd4,
		REG_MOD_HALF_WAVE = 3'd5,
		REG_CAR_HALF_WAVE = 3'd6
	} cfg_reg_t;

	localparam logic [11:0] LOG_SINE_ROM [256] = '{
		12'h859, 12'h6c3, 12'h607, 12'h58b, 12'h52e, 12'h4e4, 12'h4a6, 12'h471,
		12'h443, 12'h41a, 12'h3f5, 12'h3d3, 12'h3b5, 12'h398, 12'h37e, 12'h365,
		12'h34e, 12'h339, 12'h324, 12'h311, 12'h2ff, 12'h2ed, 12'h2dc, 12'h2cd,
		12'h2bd, 12'h2af, 12'h2a0, 12'h293, 12'h286, 12'h279, 12'h26d, 12'h261,
		12'h256, 12'h24b, 12'h240, 12'h236, 12'h22c, 12'h222, 12'h218, 12'h20f,
		12'h206, 12'h1fd, 12'h1f5, 12'h1ec, 12'h1e4, 12'h1dc, 12'h1d4, 12'h1cd,
		12'h1c5, 12'h1be, 12'h1b7, 12'h1b0, 12'h1a9, 12'h1a2, 12'h19b, 12'h195,
		12'h18f, 12'h188, 12'h182, 12'h17c, 12'h177, 12'h171, 12'h16b, 12'h166,
		12'h160, 12'h15b, 12'h155, 12'h150, 12'h14b, 12'h146, 12'h141, 12'h13c,
		12'h137, 12'h133, 12'h12e, 12'h129, 12'h125, 12'h121, 12'h11c, 12'h118,
		12'h114, 12'h10f, 12'h10b, 12'h107, 12'h103, 12'h0ff, 12'h0fb, 12'h0f8,
		12'h0f4, 12'h0f0, 12'h0ec, 12'h0e9, 12'h0e5, 12'h0e2, 12'h0de, 12'h0db,
		12'h0d7, 12'h0d4, 12'h0d1, 12'h0cd, 12'h0ca, 12'h0c7, 12'h0c4, 12'h0c1,
		12'h0be, 12'h0bb, 12'h0b8, 12'h0b5, 12'h0b2, 12'h0af, 12'h0ac, 12'h0a9,
		12'h0a7, 12'h0a4, 12'h0a1, 12'h09f, 12'h09c, 12'h099, 12'h097, 12'h094,
		12'h092, 12'h08f, 12'h08d, 12'h08a, 12'h088, 12'h086, 12'h083, 12'h081,
		12'h07f, 12'h07d, 12'h07a, 12'h078, 12'h076, 12'h074, 12'h072, 12'h070,
		12'h06e, 12'h06c, 12'h06a, 12'h068, 12'h066, 12'h064, 12'h062, 12'h060,
		12'h05e, 12'h05c, 12'h05b, 12'h059, 12'h057, 12'h055, 12'h053, 12'h052,
		12'h050, 12'h04e, 12'h04d, 12'h04b, 12'h04a, 12'h048, 12'h046, 12'h045,
		12'h043, 12'h042, 12'h040, 12'h03f, 12'h03e, 12'h03c, 12'h03b, 12'h039,
		12'h038, 12'h037, 12'h035, 12'h034, 12'h033, 12'h031, 12'h030, 12'h02f,
		12'h02e, 12'h02d, 12'h02b, 12'h02a, 12'h029, 12'h028, 12'h027, 12'h026,
		12'h025, 12'h024, 12'h023, 12'h022, 12'h021, 12'h020, 12'h01f, 12'h01e,
		12'h01d, 12'h01c, 12'h01b, 12'h01a, 12'h019, 12'h018, 12'h017, 12'h017,
		12'h016, 12'h015, 12'h014, 12'h014, 12'h013, 12'h012, 12'h011, 12'h011,
		12'h010, 12'h00f, 12'h00f, 12'h00e, 12'h00d, 12'h00d, 12'h00c, 12'h00c,
		12'h00b, 12'h00a, 12'h00a, 12'h009, 12'h009, 12'h008, 12'h008, 12'h007,
		12'h007, 12'h007, 12'h006, 12'h006, 12'h005, 12'h005, 12'h005, 12'h004,
		12'h004, 12'h004, 12'h003, 12'h003, 12'h003, 12'h002, 12'h002, 12'h002,
		12'h002, 12'h001, 12'h001, 12'h001, 12'h001, 12'h001, 12'h001, 12'h001,
		12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000
	};

	typedef logic [255:0][9:0] exp_rom_t;
	typedef logic [8:0][63:0] root_tab_t;

	localparam logic [63:0] QONE = 64'h4000_0000_0000_0000;

	// Q62 fixed-point product
	function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// Exponent table, entry i = round((2^(i/256)-1)*1024), built from repeated square roots
	function automatic exp_rom_t build_exp_rom();
		root_tab_t root;
		logic [63:0] y;
		logic [63:0] cand;
		logic [63:0] p;
		logic [63:0] e;
		exp_rom_t rom;
		root[0] = {QONE[62:0], 1'b0};
		for (int k = 1; k <= 8; k++) begin
			y = '0;
			for (int b = 62; b >= 0; b--) begin
				cand = y | (64'd1 << b);
				if (q62_mul(cand, cand) <= root[k - 1])
					y = cand;
			end
			root[k] = y;
		end
		for (int i = 0; i < 256; i++) begin
			p = QONE;
			for (int b = 0; b < 8; b++) begin
				if (((i >> b) & 1) != 0)
					p = q62_mul(p, root[8 - b]);
			end
			e = ((p - QONE) >> 51) + 64'd1;
			rom[i] = e[10:1];
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

	// One operator: log-sine lookup, attenuation, exponent lookup and shift; 13-bit signed result
	function automatic logic [12:0] op_out(input logic [9:0] phase, input logic half,
			input logic [8:0] att);
		logic [7:0] idx;
		logic [11:0] lg;
		logic [6:0] att_c;
		logic [12:0] sum;
		logic [11:0] t;
		logic [11:0] mag;
		idx = phase[7:0] ^ {8{phase[8]}};
		lg = LOG_SINE_ROM[idx];
		if (phase[9] && half)
			lg = 12'hFFF;
		att_c = (att > 9'd127) ? 7'd127 : att[6:0];
		sum = {1'b0, lg} + {2'b0, att_c, 4'b0};
		t = {1'b1, EXP_ROM[~sum[7:0]], 1'b0};
		mag = sum[12] ? 12'd0 : (t >> sum[11:8]);
		return phase[9] ? ~{1'b0, mag} : {1'b0, mag};
	endfunction

endpackage

// ===== rtl/fm_two_operator_voice_top.sv =====
// Two-operator FM voice: input register, single-cycle operator pair and result register.
//
// One item is accepted every clock cycle while the output is not stalled. Each sample is
// valid on out_valid once its request has landed in the input register and then moved on
// to the result register. With out_ready held high a sample leaves every cycle. A stalled
// output holds up the input only once both registers are full. For the modulator feedback,
// the two previous modulator outputs are updated as an item moves into the result register,
// so the path from those registers through both operators sets the clock limit.
// Configuration is taken at any time on its own channel, which is always ready, and acts on
// any request still in the input register. Register indexes beyond the list are ignored.
module fm_two_operator_voice_top import fm2op_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [9:0] mod_phase,
	input  logic [9:0] car_phase,
	input  logic [6:0] mod_envelope,
	input  logic [6:0] car_envelope,
	input  logic [3:0] mod_tremolo,
	input  logic [3:0] car_tremolo,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [8:0] sample
);

	logic [5:0] total_level_q;
	logic [2:0] feedback_q;
	logic [3:0] volume_q;
	logic [6:0] mod_key_scale_q;
	logic [6:0] car_key_scale_q;
	logic       mod_half_wave_q;
	logic       car_half_wave_q;

	logic [11:0] last_mod_q;
	logic [11:0] older_mod_q;

	logic       vld_s1;
	logic [9:0] mod_phase_s1;
	logic [9:0] car_phase_s1;
	logic [6:0] mod_env_s1;
	logic [6:0] car_env_s1;
	logic [3:0] mod_trem_s1;
	logic [3:0] car_trem_s1;

	logic       out_vld_q;
	logic [8:0] sample_q;

	logic               take;
	logic signed [12:0] fb_sum;
	logic signed [12:0] fb_shift;
	logic [9:0]         mod_ph;
	logic [9:0]         car_ph;
	logic [8:0]         mod_att;
	logic [8:0]         car_att;
	logic [12:0]        mod_raw;
	logic [12:0]        car_raw;
	logic [11:0]        mod_out;
	logic [8:0]         car_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_level_q   <= '0;
			feedback_q      <= '0;
			volume_q        <= '0;
			mod_key_scale_q <= '0;
			car_key_scale_q <= '0;
			mod_half_wave_q <= 1'b0;
			car_half_wave_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_TOTAL_LEVEL:   total_level_q   <= cfg_data[5:0];
				REG_FEEDBACK:      feedback_q      <= cfg_data[2:0];
				REG_VOLUME:        volume_q        <= cfg_data[3:0];
				REG_MOD_KEY_SCALE: mod_key_scale_q <= cfg_data;
				REG_CAR_KEY_SCALE: car_key_scale_q <= cfg_data;
				REG_MOD_HALF_WAVE: mod_half_wave_q <= cfg_data[0];
				REG_CAR_HALF_WAVE: car_half_wave_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign take     = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mod_phase_s1 <= mod_phase;
			car_phase_s1 <= car_phase;
			mod_env_s1   <= mod_envelope;
			car_env_s1   <= car_envelope;
			mod_trem_s1  <= mod_tremolo;
			car_trem_s1  <= car_tremolo;
		end
	end

	// modulator with self feedback, floor shift of the sum of the last two outputs
	always_comb begin
		fb_sum = $signed({last_mod_q[11], last_mod_q}) + $signed({older_mod_q[11], older_mod_q});
		if (feedback_q == 3'd0)
			fb_shift = '0;
		else
			fb_shift = fb_sum >>> (4'd8 - {1'b0, feedback_q});
		mod_ph  = mod_phase_s1 + fb_shift[9:0];
		mod_att = {2'b0, total_level_q, 1'b0} + {2'b0, mod_key_scale_q}
			+ {2'b0, mod_env_s1} + {5'b0, mod_trem_s1};
		mod_raw = op_out(mod_ph, mod_half_wave_q, mod_att);
		mod_out = (mod_env_s1[6:2] == 5'h1F) ? 12'd0 : mod_raw[12:1];
	end

	always_comb begin
		car_ph  = car_phase_s1 + {mod_out[8:0], 1'b0};
		car_att = {2'b0, volume_q, 3'b0} + {2'b0, car_key_scale_q}
			+ {2'b0, car_env_s1} + {5'b0, car_trem_s1};
		car_raw = op_out(car_ph, car_half_wave_q, car_att);
		car_out = (car_env_s1[6:2] == 5'h1F) ? 9'd0 : car_raw[12:4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_mod_q  <= '0;
			older_mod_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (take) begin
				last_mod_q  <= mod_out;
				older_mod_q <= last_mod_q;
				out_vld_q   <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			sample_q <= 9'd255 - car_out;
	end

	assign out_valid = out_vld_q;
	assign sample    = sample_q;

endmodule

// ===== tb/sv/fm_voice_checker.sv =====
// Checker for the two-operator FM voice: tracks registers, predicts each sample and compares.
module fm_voice_checker import fm2op_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [9:0] mod_phase,
	input  logic [9:0] car_phase,
	input  logic [6:0] mod_envelope,
	input  logic [6:0] car_envelope,
	input  logic [3:0] mod_tremolo,
	input  logic [3:0] car_tremolo,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [8:0] sample,
	output int         errors,
	output int         pending,
	output int         samples_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam real PI = 3.14159265358979323846;

	int sine_att_tab [256];
	int pow2_frac_tab [256];

	logic [5:0] tl_q;
	logic [2:0] fb_q;
	logic [3:0] vol_q;
	logic [6:0] mks_q;
	logic [6:0] cks_q;
	logic       mhw_q;
	logic       chw_q;

	int mod_prev;
	int mod_older;

	logic [8:0] expected_samples [$];
	logic [8:0] want;

	initial begin
		real x;
		errors = 0;
		pending = 0;
		samples_seen = 0;
		for (int i = 0; i < 256; i++) begin
			x = -$ln($sin((i + 0.5) * PI / 512.0)) / $ln(2.0) * 256.0;
			sine_att_tab[i] = $rtoi($floor(x + 0.5));
			x = ($pow(2.0, i / 256.0) - 1.0) * 1024.0;
			pow2_frac_tab[i] = $rtoi($floor(x + 0.5));
		end
	end

	// signed operator output from a 10-bit phase and an unclamped attenuation
	function automatic int operator_value(input int phase, input logic half, input int atten);
		int idx;
		int lg;
		int v;
		int sh;
		int mag;
		idx = phase & 'hFF;
		if ((phase & 'h100) != 0)
			idx = idx ^ 'hFF;
		lg = sine_att_tab[idx];
		if ((phase & 'h200) != 0 && half)
			lg = 'hFFF;
		if (atten > 127)
			atten = 127;
		v = lg + 16 * atten;
		sh = v >> 8;
		mag = (sh >= 16) ? 0 : (((pow2_frac_tab[(v & 'hFF) ^ 'hFF] << 1) | 'h800) >> sh);
		return ((phase & 'h200) != 0) ? -mag - 1 : mag;
	endfunction

	// one voice step; advances the feedback history
	function automatic logic [8:0] voice_sample(input logic [9:0] mp, input logic [9:0] cp,
			input logic [6:0] me, input logic [6:0] ce, input logic [3:0] mt,
			input logic [3:0] ct);
		int fbk;
		int m;
		int c;
		int ph;
		int att;
		logic [8:0] r;
		fbk = 0;
		m = 0;
		c = 0;
		if (fb_q != 0)
			fbk = (mod_prev + mod_older) >>> (8 - int'(fb_q));
		if ((me & 7'h7C) != 7'h7C) begin
			ph = (int'(mp) + fbk) & 'h3FF;
			att = 2 * int'(tl_q) + int'(mks_q) + int'(me) + int'(mt);
			m = operator_value(ph, mhw_q, att) >>> 1;
		end
		mod_older = mod_prev;
		mod_prev = m;
		if ((ce & 7'h7C) != 7'h7C) begin
			ph = (int'(cp) + 2 * m) & 'h3FF;
			att = 8 * int'(vol_q) + int'(cks_q) + int'(ce) + int'(ct);
			c = operator_value(ph, chw_q, att) >>> 4;
		end
		r = 9'(255 - c);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q = '0;
			fb_q = '0;
			vol_q = '0;
			mks_q = '0;
			cks_q = '0;
			mhw_q = 1'b0;
			chw_q = 1'b0;
			mod_prev = 0;
			mod_older = 0;
			expected_samples.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TOTAL_LEVEL:   tl_q = cfg_data[5:0];
					REG_FEEDBACK:      fb_q = cfg_data[2:0];
					REG_VOLUME:        vol_q = cfg_data[3:0];
					REG_MOD_KEY_SCALE: mks_q = cfg_data;
					REG_CAR_KEY_SCALE: cks_q = cfg_data;
					REG_MOD_HALF_WAVE: mhw_q = cfg_data[0];
					REG_CAR_HALF_WAVE: chw_q = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_samples.push_back(voice_sample(mod_phase, car_phase, mod_envelope,
					car_envelope, mod_tremolo, car_tremolo));
			if (out_valid && out_ready) begin
				samples_seen++;
				if (expected_samples.size() == 0) begin
					$error("sample: expected none, got %0d", sample);
					errors++;
				end else begin
					want = expected_samples.pop_front();
					if (sample !== want) begin
						$error("sample: expected %0d, got %0d", want, sample);
						errors++;
					end
				end
			end
		end
		pending = expected_samples.size();
	end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the two-operator FM voice: stimulus, idling, timeout and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fm2op_pkg::*;

	localparam logic [2:0] CFG_NO_REG = 3'd7;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 125;
	localparam int CYCLE_LIMIT = 200000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [9:0] mod_phase = '0;
	logic [9:0] car_phase = '0;
	logic [6:0] mod_envelope = '0;
	logic [6:0] car_envelope = '0;
	logic [3:0] mod_tremolo = '0;
	logic [3:0] car_tremolo = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [8:0] sample;

	int  fail_count;
	int  pending;
	int  samples_seen;
	int  cycle_count = 0;
	int  requests_sent = 0;
	int  settings_count = 0;
	bit  steady = 1'b0;

	fm_two_operator_voice_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mod_phase(mod_phase), .car_phase(car_phase),
		.mod_envelope(mod_envelope), .car_envelope(car_envelope),
		.mod_tremolo(mod_tremolo), .car_tremolo(car_tremolo),
		.out_valid(out_valid), .out_ready(out_ready), .sample(sample)
	);

	fm_voice_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mod_phase(mod_phase), .car_phase(car_phase),
		.mod_envelope(mod_envelope), .car_envelope(car_envelope),
		.mod_tremolo(mod_tremolo), .car_tremolo(car_tremolo),
		.out_valid(out_valid), .out_ready(out_ready), .sample(sample),
		.errors(fail_count), .pending(pending), .samples_seen(samples_seen)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 21);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[fm_two_operator_voice_top] ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_all(input logic [6:0] tl, input logic [6:0] fb, input logic [6:0] vol,
			input logic [6:0] mks, input logic [6:0] cks, input logic [6:0] mhw,
			input logic [6:0] chw);
		write_reg(REG_TOTAL_LEVEL, tl);
		write_reg(REG_FEEDBACK, fb);
		write_reg(REG_VOLUME, vol);
		write_reg(REG_MOD_KEY_SCALE, mks);
		write_reg(REG_CAR_KEY_SCALE, cks);
		write_reg(REG_MOD_HALF_WAVE, mhw);
		write_reg(REG_CAR_HALF_WAVE, chw);
		// an unused index must leave every register alone
		write_reg(CFG_NO_REG, 7'($urandom_range(127)));
		cfg_valid <= 1'b0;
		@(posedge clk);
		settings_count++;
	endtask

	task automatic send_req(input logic [9:0] mp, input logic [9:0] cp, input logic [6:0] me,
			input logic [6:0] ce, input logic [3:0] mt, input logic [3:0] ct);
		while (!steady && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mod_phase <= mp;
		car_phase <= cp;
		mod_envelope <= me;
		car_envelope <= ce;
		mod_tremolo <= mt;
		car_tremolo <= ct;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		requests_sent++;
	endtask

	// registers only change once every sample has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [6:0] reg_value();
		case ($urandom_range(5))
			0: return 7'd0;
			1: return 7'h7F;
			2: return 7'($urandom_range(127));
			default: return 7'($urandom_range(7));
		endcase
	endfunction

	function automatic logic [6:0] rand_env();
		case ($urandom_range(9))
			0: return 7'($urandom_range(127));
			1: return 7'h7C | 7'($urandom_range(3));
			default: return 7'($urandom_range(47));
		endcase
	endfunction

	function automatic logic [3:0] rand_trem();
		return ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(13));
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: phase corners, muting, tremolo range
		send_req(10'd0, 10'd0, 7'd0, 7'd0, 4'd0, 4'd0);
		send_req(10'h3FF, 10'h3FF, 7'd0, 7'd0, 4'd0, 4'd0);
		send_req(10'h100, 10'h200, 7'd1, 7'd2, 4'd13, 4'd13);
		send_req(10'h2FF, 10'h0FF, 7'd0, 7'd0, 4'd0, 4'd0);
		send_req(10'h155, 10'h2AA, 7'h7F, 7'h7F, 4'hF, 4'hF);
		send_req(10'h0AA, 10'h355, 7'h7C, 7'h7B, 4'd0, 4'd0);
		send_req(10'h200, 10'h080, 7'h03, 7'h7C, 4'd0, 4'd0);
		send_req(10'h080, 10'h380, 7'h7B, 7'h7B, 4'd13, 4'd13);
		drain();

		// everything at full scale: saturated attenuation, half wave, large shift
		write_all(7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F);
		send_req(10'h200, 10'h200, 7'd0, 7'd0, 4'd0, 4'd0);
		send_req(10'h3FF, 10'h3FF, 7'd0, 7'd0, 4'd0, 4'd0);
		send_req(10'h000, 10'h100, 7'h7F, 7'd0, 4'hF, 4'hF);
		send_req(10'h2C0, 10'h140, 7'd0, 7'h7C, 4'd0, 4'd0);
		drain();

		// strongest feedback, then the weakest
		write_all(7'd0, 7'd7, 7'd0, 7'd0, 7'd0, 7'd0, 7'd1);
		for (int k = 0; k < 6; k++)
			send_req(10'(k * 'h90), 10'(k * 'h1A5), 7'd0, 7'd0, 4'd0, 4'd0);
		drain();
		write_all(7'd0, 7'd1, 7'd0, 7'd0, 7'd0, 7'd1, 7'd0);
		for (int k = 0; k < 4; k++)
			send_req(10'(k * 'hC3), 10'(k * 'h77), 7'd0, 7'd0, 4'd0, 4'd0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0)
				write_all(7'($urandom_range(3)), 7'($urandom_range(1, 7)), 7'd0,
					7'($urandom_range(3)), 7'($urandom_range(3)), 7'd0, 7'd0);
			else
				write_all(reg_value(), reg_value(), reg_value(), reg_value(), reg_value(),
					reg_value(), reg_value());
			steady = (p == PHASES / 2);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_req(10'($urandom_range(1023)), 10'($urandom_range(1023)), rand_env(),
					rand_env(), rand_trem(), rand_trem());
			drain();
			steady = 1'b0;
		end

		repeat (10) @(posedge clk);
		$display("Sent %0d requests under %0d register settings, %0d samples compared.",
			requests_sent, settings_count, samples_seen);
		$display("Covered muting, saturation, half wave, feedback 1..7 and random back-pressure.");
		if (fail_count == 0)
			$display("[fm_two_operator_voice_top] OK");
		else
			$display("[fm_two_operator_voice_top] ERROR");
		$finish;
	end

endmodule
